// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the RTL of the transform unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ----- hw/rtl/dntt_pkg.sv -----
// Package with the types and constants of the transform unit.
`default_nettype none
package dntt_pkg;

  // Configuration port
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 32;
  localparam logic [CfgIdxW-1:0] CFG_ROOT    = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_MODULUS = 1'd1;

  // Reset values of the registers
  localparam logic [31:0] ROOT_RESET    = 32'd3;
  localparam logic [31:0] MODULUS_RESET = 32'd65537;

  // Width of the payload fields
  localparam int unsigned FieldW = 32;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_ROW,
    S_READ,
    S_MUL1,
    S_WAIT1,
    S_MUL2,
    S_WAIT2,
    S_NEXTROW,
    S_WAIT3,
    S_EMIT
  } seq_state_e;

endpackage
`default_nettype wire

// ----- hw/rtl/dntt_if.sv -----
// Stream interfaces for sample beats and coefficient beats.
`default_nettype none
interface dntt_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] sample_value;
  logic        last_in;
  modport source(output valid, output sample_value, output last_in, input ready);
  modport sink(input valid, input sample_value, input last_in, output ready);
endinterface

interface dntt_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] coefficient;
  logic        last_out;
  logic        too_long;
  modport source(output valid, output coefficient, output last_out, output too_long,
                 input ready);
  modport sink(input valid, input coefficient, input last_out, input too_long,
               output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/dntt_ram.sv -----
// Generic single-port-write, registered-read RAM.
`default_nettype none
module dntt_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ----- hw/rtl/dntt_mulmod.sv -----
// Modular multiplier: one product, then a restoring reduction one bit a cycle.
`default_nettype none
module dntt_mulmod #(
  parameter int unsigned W = 32
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  wire logic [W-1:0] a_i,
  input  wire logic [W-1:0] b_i,
  input  wire logic [W-1:0] m_i,
  output logic              done_o,
  output logic      [W-1:0] res_o
);

  localparam int unsigned PW = 2 * W;
  localparam int unsigned CntW = $clog2(PW + 1);

  logic [PW-1:0]   prod_d, prod_q;
  logic [W-1:0]    r_d, r_q;
  logic [CntW-1:0] cnt_d, cnt_q;
  logic            busy_d, busy_q;
  logic            done_d, done_q;
  logic [W:0]      rem_shift;
  logic [W:0]      rem_sub;
  logic            rem_ge;

  // One restoring step: shift in the next product bit, subtract if it fits.
  always_comb begin
    rem_shift = {r_q, prod_q[PW-1]};
    rem_ge    = rem_shift >= {1'b0, m_i};
    rem_sub   = rem_shift - {1'b0, m_i};
  end

  // Next values of the reduction registers.
  always_comb begin
    prod_d = prod_q;
    r_d    = r_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      prod_d = a_i * b_i;
      r_d    = '0;
      cnt_d  = CntW'(PW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      prod_d = {prod_q[PW-2:0], 1'b0};
      r_d    = rem_ge ? rem_sub[W-1:0] : rem_shift[W-1:0];
      cnt_d  = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
      r_q    <= '0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
      r_q    <= r_d;
    end
  end

  // The product register carries no control meaning.
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  assign done_o = done_q;
  assign res_o  = r_q;

endmodule
`default_nettype wire

// ----- hw/rtl/direct_number_theoretic_transform_unit.sv -----
// Throughput: one sample beat a cycle while loading; no new sample is taken while a
// transform runs, its rate set by the single bit-serial reducer and the sample RAM port.
// Reset: asynchronous, active low; clears the counters, sets the twiddles to one and the
// registers to root 3 and modulus 65537. The sample RAM is not cleared.
`default_nettype none
module direct_number_theoretic_transform_unit
  import dntt_pkg::*;
#(
  parameter int unsigned MAX_POINTS   = 64,
  parameter int unsigned RESIDUE_BITS = 32
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  dntt_in_if.sink                  in_i,
  dntt_out_if.source               out_o
);

`include "assert_macros.svh"

  localparam int unsigned W  = RESIDUE_BITS;
  localparam int unsigned CW = $clog2(MAX_POINTS + 1);
  localparam int unsigned AW = $clog2(MAX_POINTS);

  seq_state_e st_d, st_q;

  logic [W-1:0]  root_q, mod_q;
  logic [CW-1:0] count_q, k_q, n_q;
  logic          ovf_q;
  logic [W-1:0]  row_q, term_q, acc_q;
  logic          ov_q, olast_q, otl_q;
  logic [W-1:0]  oc_q;

  logic          in_fire, store_ok, m_ok, out_free, last_term, last_row;
  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [W-1:0]  ram_rdata;
  logic          mm_start, mm_done;
  logic [W-1:0]  mm_a, mm_b, mm_res;
  logic [W:0]    acc_sum, acc_sub;

  assign in_fire   = in_i.valid & in_i.ready;
  assign store_ok  = count_q < CW'(MAX_POINTS);
  assign m_ok      = mod_q >= W'(2);
  assign out_free  = !ov_q || out_o.ready;
  assign last_term = n_q == count_q - CW'(1);
  assign last_row  = k_q == count_q - CW'(1);

  // Sample store.
  dntt_ram #(
    .WIDTH(W),
    .DEPTH(MAX_POINTS)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_addr),
    .wdata_i(in_i.sample_value[W-1:0]),
    .raddr_i(ram_addr),
    .rdata_o(ram_rdata)
  );

  // Shared modular multiplier.
  dntt_mulmod #(
    .W(W)
  ) u_mulmod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mm_start),
    .a_i    (mm_a),
    .b_i    (mm_b),
    .m_i    (mod_q),
    .done_o (mm_done),
    .res_o  (mm_res)
  );

  // Next state of the sequencer.
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      S_IDLE:    if (in_fire && in_i.last_in) st_d = S_ROW;
      S_ROW:     st_d = m_ok ? S_READ : S_EMIT;
      S_READ:    st_d = S_MUL1;
      S_MUL1:    st_d = S_WAIT1;
      S_WAIT1:   if (mm_done) st_d = S_MUL2;
      S_MUL2:    st_d = S_WAIT2;
      S_WAIT2:   if (mm_done) st_d = last_term ? S_NEXTROW : S_READ;
      S_NEXTROW: st_d = S_WAIT3;
      S_WAIT3:   if (mm_done) st_d = S_EMIT;
      S_EMIT:    if (out_free) st_d = last_row ? S_IDLE : S_ROW;
      default:   st_d = S_IDLE;
    endcase
  end

  // Outputs of the sequencer: input ready, RAM access and multiplier operands.
  always_comb begin
    in_i.ready = 1'b0;
    ram_we     = 1'b0;
    ram_addr   = n_q[AW-1:0];
    mm_start   = 1'b0;
    mm_a       = term_q;
    mm_b       = row_q;
    unique case (st_q)
      S_IDLE: begin
        in_i.ready = 1'b1;
        ram_we     = in_fire && store_ok;
        ram_addr   = count_q[AW-1:0];
      end
      S_MUL1: begin
        mm_start = 1'b1;
        mm_a     = ram_rdata;
        mm_b     = term_q;
      end
      S_MUL2: begin
        mm_start = 1'b1;
      end
      S_NEXTROW: begin
        mm_start = 1'b1;
        mm_a     = row_q;
        mm_b     = root_q;
      end
      default: ;
    endcase
  end

  // Accumulation modulo m; both operands are already below m.
  always_comb begin
    acc_sum = {1'b0, acc_q} + {1'b0, mm_res};
    acc_sub = acc_sum - {1'b0, mod_q};
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_q <= ROOT_RESET[W-1:0];
      mod_q  <= MODULUS_RESET[W-1:0];
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ROOT:    root_q <= cfg_data_i[W-1:0];
        CFG_MODULUS: mod_q  <= cfg_data_i[W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer, counters, twiddles and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= S_IDLE;
      count_q <= '0;
      ovf_q   <= 1'b0;
      k_q     <= '0;
      n_q     <= '0;
      row_q   <= W'(1);
      term_q  <= W'(1);
      acc_q   <= '0;
      ov_q    <= 1'b0;
      oc_q    <= '0;
      olast_q <= 1'b0;
      otl_q   <= 1'b0;
    end else begin
      st_q <= st_d;
      // The output beat is loaded on emit and released once taken.
      if (st_q == S_EMIT && out_free) begin
        ov_q <= 1'b1;
      end else if (out_o.ready) begin
        ov_q <= 1'b0;
      end
      unique case (st_q)
        S_IDLE: begin
          if (in_fire) begin
            if (store_ok) begin
              count_q <= count_q + CW'(1);
            end else begin
              ovf_q <= 1'b1;
            end
            if (in_i.last_in) begin
              k_q   <= '0;
              row_q <= W'(1);
            end
          end
        end
        S_ROW: begin
          acc_q  <= '0;
          term_q <= W'(1);
          n_q    <= '0;
        end
        S_WAIT1: begin
          if (mm_done) begin
            acc_q <= (acc_sum >= {1'b0, mod_q}) ? acc_sub[W-1:0] : acc_sum[W-1:0];
          end
        end
        S_WAIT2: begin
          if (mm_done) begin
            term_q <= mm_res;
            n_q    <= n_q + CW'(1);
          end
        end
        S_WAIT3: begin
          if (mm_done) begin
            row_q <= mm_res;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            oc_q    <= acc_q;
            olast_q <= last_row;
            otl_q   <= ovf_q;
            k_q     <= k_q + CW'(1);
            if (last_row) begin
              count_q <= '0;
              ovf_q   <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign out_o.valid       = ov_q;
  assign out_o.coefficient = FieldW'(oc_q);
  assign out_o.last_out    = olast_q;
  assign out_o.too_long    = otl_q;

  // The fill count never passes the store depth.
  `ASSERT_IMPL(a_count_bound, 1'b1, count_q <= CW'(MAX_POINTS))
  // A coefficient leaving the sequencer shows up on the output in the next cycle.
  `ASSERT_NEXT(a_emit_shows, st_q == S_EMIT && out_free, out_o.valid)
  // The reducer only finishes while the sequencer waits for it.
  `ASSERT_IMPL(a_done_waits, mm_done,
               st_q == S_WAIT1 || st_q == S_WAIT2 || st_q == S_WAIT3)
  // A transform never runs past the stored vector.
  `ASSERT_IMPL(a_term_bound, st_q == S_READ, n_q < count_q)

endmodule
`default_nettype wire

// ----- bench/tb.sv -----
// Self-checking bench for the direct transform unit: loads vectors and checks coefficients.
`default_nettype none
module tb;
  import dntt_pkg::*;

  localparam int unsigned StoreDepth = 64;
  localparam int unsigned StallLimit = 100000;
  localparam int unsigned RandomItems = 165;

  typedef struct packed {
    logic [31:0] coefficient;
    logic        last_out;
    logic        too_long;
  } coeff_beat_t;

  // Holds its own copy of the sample store and registers, and the coefficients still due.
  class coeff_scoreboard;
    logic [31:0] root_q;
    logic [31:0] modulus_q;
    logic [31:0] samples[StoreDepth];
    int unsigned fill;
    bit          dropped;
    coeff_beat_t due_q[$];
    int unsigned errors;

    function void reset_state();
      root_q    = ROOT_RESET;
      modulus_q = MODULUS_RESET;
      fill      = 0;
      dropped   = 1'b0;
      errors    = 0;
      due_q.delete();
    endfunction

    function void set_register(logic [CfgIdxW-1:0] idx, logic [31:0] value);
      if (idx == CFG_ROOT) begin
        root_q = value;
      end else if (idx == CFG_MODULUS) begin
        modulus_q = value;
      end
    endfunction

    // Stores one sample and, on the final one, works out every coefficient of the vector.
    function void note_sample(logic [31:0] value, logic last);
      longint unsigned m, row, term, acc;
      coeff_beat_t beat;
      if (fill < StoreDepth) begin
        samples[fill] = value;
        fill++;
      end else begin
        dropped = 1'b1;
      end
      if (!last) return;
      m   = modulus_q;
      row = 1;
      for (int unsigned k = 0; k < fill; k++) begin
        acc  = 0;
        term = 1;
        if (m >= 2) begin
          for (int unsigned n = 0; n < fill; n++) begin
            acc  = (acc + (longint'(samples[n]) * term) % m) % m;
            term = (term * row) % m;
          end
          row = (row * longint'(root_q)) % m;
        end
        beat.coefficient = acc[31:0];
        beat.last_out    = (k + 1 == fill);
        beat.too_long    = dropped;
        due_q.push_back(beat);
      end
      fill    = 0;
      dropped = 1'b0;
    endfunction

    function void check_coefficient(coeff_beat_t got);
      coeff_beat_t want;
      if (due_q.size() == 0) begin
        $display("%0t: unexpected coefficient beat, actual %h/%b/%b", $time,
                 got.coefficient, got.last_out, got.too_long);
        errors++;
        return;
      end
      want = due_q.pop_front();
      if (got.coefficient !== want.coefficient) begin
        $display("%0t: coefficient expected %h actual %h", $time, want.coefficient,
                 got.coefficient);
        errors++;
      end
      if (got.last_out !== want.last_out) begin
        $display("%0t: last_out expected %b actual %b", $time, want.last_out, got.last_out);
        errors++;
      end
      if (got.too_long !== want.too_long) begin
        $display("%0t: too_long expected %b actual %b", $time, want.too_long, got.too_long);
        errors++;
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  dntt_in_if  in_if();
  dntt_out_if out_if();

  direct_number_theoretic_transform_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  coeff_scoreboard sb = new();
  bit          idling_on;
  bit          hold_off_req;
  bit          held_off;
  int unsigned random_sent;

  // Clock.
  initial clk_i = 1'b0;
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Writes one register while the block is idle; the caller drops the enable.
  task automatic write_register(logic [CfgIdxW-1:0] idx, logic [31:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    sb.set_register(idx, value);
  endtask

  task automatic configure(logic [31:0] root, logic [31:0] modulus);
    write_register(CFG_ROOT, root);
    write_register(CFG_MODULUS, modulus);
    cfg_we_i <= 1'b0;
  endtask

  // Offers one sample beat and returns once it has been taken.
  task automatic send_sample(logic [31:0] value, logic last);
    bit taken;
    if (idling_on && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.sample_value <= value;
    in_if.last_in      <= last;
    do begin
      @(negedge clk_i);
      taken = in_if.ready;
      @(posedge clk_i);
    end while (!taken);
    sb.note_sample(value, last);
  endtask

  task automatic send_vector(int unsigned len);
    for (int unsigned i = 0; i < len; i++) begin
      send_sample($urandom(), i + 1 == len);
    end
  endtask

  // Waits until every coefficient due has come back, then lets the block settle.
  task automatic drain();
    in_if.valid <= 1'b0;
    while (sb.due_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // Coefficient receiver with random stall bursts and one long hold-off.
  initial begin
    coeff_beat_t got;
    bit          seen;
    int unsigned stall_left;
    stall_left   = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(negedge clk_i);
      seen = out_if.valid && out_if.ready;
      got  = '{out_if.coefficient, out_if.last_out, out_if.too_long};
      @(posedge clk_i);
      if (seen) sb.check_coefficient(got);
      if (hold_off_req) begin
        out_if.ready <= 1'b0;
        for (int i = 0; i < 3000; i++) @(posedge clk_i);
        hold_off_req = 1'b0;
        out_if.ready <= 1'b1;
      end else if (stall_left != 0) begin
        stall_left--;
        out_if.ready <= (stall_left == 0);
      end else if (idling_on && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(1, 11);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles in which no beat moves on either side.
  initial begin
    int unsigned quiet;
    bit          moved;
    quiet = 0;
    forever begin
      @(negedge clk_i);
      moved = (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready);
      @(posedge clk_i);
      quiet = moved ? 0 : quiet + 1;
      if (quiet >= StallLimit) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // Stimulus.
  initial begin
    int unsigned len;
    sb.reset_state();
    idling_on          = 1'b1;
    hold_off_req       = 1'b0;
    held_off           = 1'b0;
    random_sent        = 0;
    rst_ni            <= 1'b0;
    cfg_we_i          <= 1'b0;
    cfg_idx_i         <= CFG_ROOT;
    cfg_data_i        <= '0;
    in_if.valid        <= 1'b0;
    in_if.sample_value <= '0;
    in_if.last_in      <= 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset registers, a single-point vector and extreme unreduced samples.
    send_sample(32'hFFFF_FFFF, 1'b1);
    send_sample(32'h0000_0000, 1'b0);
    send_sample(32'hFFFF_FFFF, 1'b0);
    send_sample(32'h0001_0000, 1'b0);
    send_sample(32'h0001_0001, 1'b1);
    drain();
    // Modulus zero and one give all-zero coefficients.
    configure(32'd3, 32'd0);
    send_sample(32'h1234_5678, 1'b0);
    send_sample(32'hFFFF_FFFF, 1'b1);
    drain();
    configure(32'hFFFF_FFFF, 32'd1);
    send_sample(32'h8000_0000, 1'b0);
    send_sample(32'h0000_0001, 1'b1);
    drain();
    // Smallest proper modulus, then the widest modulus with extreme roots.
    configure(32'd1, 32'd2);
    send_vector(3);
    drain();
    configure(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_vector(4);
    drain();
    configure(32'd0, 32'hFFFF_FFFB);
    send_vector(3);
    drain();
    // Store full: two extra samples are dropped, the last of them closing the vector.
    configure(32'd3, 32'd65537);
    idling_on = 1'b0;
    send_vector(StoreDepth + 2);
    drain();
    idling_on = 1'b1;

    // Random phases with random register settings.
    while (random_sent < RandomItems) begin
      case ($urandom_range(0, 5))
        0: configure($urandom(), $urandom());
        1: configure($urandom(), $urandom_range(2, 20));
        2: configure(32'd3, 32'd65537);
        3: configure($urandom(), 32'hFFFF_FFFF);
        4: configure($urandom(), $urandom_range(0, 1));
        default: configure($urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0, $urandom());
      endcase
      if (random_sent > RandomItems - 40) idling_on = 1'b0;
      // One long receiver hold-off while several vectors are still being offered.
      if (random_sent >= 60 && !held_off) begin
        hold_off_req = 1'b1;
        held_off     = 1'b1;
      end
      repeat ($urandom_range(2, 5)) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 6);
        send_vector(len);
        random_sent += len;
      end
      drain();
    end

    if (sb.errors == 0 && sb.due_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire
